// ----- hw/rtl/mtx_pkg.sv -----
`timescale 1ns / 1ps

package mtx_pkg;

  localparam int unsigned WordCount = 624;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned WordW     = 32;

  localparam logic [AddrW-1:0] PosFull  = 10'd624;  // twist pending
  localparam logic [AddrW-1:0] PosLast  = 10'd623;
  localparam logic [AddrW-1:0] FarStep  = 10'd397;
  localparam logic [AddrW-1:0] FarWrap  = 10'd227;  // WordCount - FarStep

  localparam logic [WordW-1:0] InitMult = 32'h6c078965;
  localparam logic [WordW-1:0] TwistXor = 32'h9908b0df;
  localparam logic [WordW-1:0] TemperB  = 32'h9d2c5680;
  localparam logic [WordW-1:0] TemperC  = 32'hefc60000;

  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SMUL = 7'b0000010,
    S_SADD = 7'b0000100,
    S_RD1  = 7'b0001000,
    S_RD2  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  function automatic logic [WordW-1:0] twist_word(logic [WordW-1:0] cur,
                                                  logic [WordW-1:0] nxt,
                                                  logic [WordW-1:0] far);
    logic [WordW-1:0] y;
    logic [WordW-1:0] v;
    y = {cur[WordW-1], nxt[WordW-2:0]};
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistXor;
    end
    return v;
  endfunction

  function automatic logic [WordW-1:0] temper(logic [WordW-1:0] r);
    logic [WordW-1:0] t;
    t = r ^ (r >> 11);
    t = t ^ ((t << 7) & TemperB);
    t = t ^ ((t << 15) & TemperC);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

// ----- hw/rtl/mtx_ram.sv -----
`timescale 1ns / 1ps

module mtx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mt19937_keystream_byte_xor.sv -----
`timescale 1ns / 1ps
// Data byte: the result is registered in S_WR, or held in S_OUT while the output stalls, and
// the next item is taken only once back in S_IDLE, so one byte at a time (three serial
// reads on the single read port of the state RAM, then the write-back of the twisted word).
// Seed: busy after the transfer (multiply, then add and write, per word).
// Reset clears control state and sets the position to 624; the state RAM is not cleared.
module mt19937_keystream_byte_xor
  import mtx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] seed_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o
);

  state_e state_q, state_d;

  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;

  logic [WordW-1:0] prev_q, prev_d;
  logic [WordW-1:0] prod_q, prod_d;
  logic [WordW-1:0] cur_q, cur_d;
  logic [WordW-1:0] nxt_q, nxt_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       res_q, res_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic             in_xfer;
  logic             out_free;
  logic [AddrW-1:0] pos_eff;
  logic [AddrW-1:0] k_next;
  logic [AddrW-1:0] k_far;
  logic [WordW-1:0] seed_word;
  logic [WordW-1:0] new_word;
  logic [WordW-1:0] tempered;
  logic [7:0]       key_byte;

  mtx_ram #(
    .Width(WordW),
    .Depth(WordCount)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  assign pos_eff   = (pos_q >= PosFull) ? '0 : pos_q;
  assign k_next    = (k_q == PosLast) ? '0 : k_q + 10'd1;
  assign k_far     = (k_q >= FarWrap) ? k_q - FarWrap : k_q + FarStep;
  assign seed_word = prod_q + {{(WordW-AddrW){1'b0}}, idx_q};
  // positions below k are already in the new generation, the rest still old,
  // so twisting lazily here matches a full in-place twist
  assign new_word  = twist_word(cur_q, nxt_q, ram_rdata);
  assign tempered  = temper(new_word);
  assign key_byte  = data_q ^ tempered[8:1];

  always_comb begin
    case (state_q)
      S_IDLE:  ram_raddr = pos_eff;
      S_RD1:   ram_raddr = k_next;
      S_RD2:   ram_raddr = k_far;
      default: ram_raddr = k_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    k_d         = k_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    data_d      = data_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    ram_we      = 1'b0;
    ram_waddr   = k_q;
    ram_wdata   = new_word;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_SEED) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_i;
            prev_d    = seed_i;
            idx_d     = 10'd1;
            pos_d     = PosFull;
            state_d   = S_SMUL;
          end else begin
            k_d     = pos_eff;
            data_d  = data_byte_i;
            state_d = S_RD1;
          end
        end
      end
      S_SMUL: begin
        prod_d  = InitMult * (prev_q ^ (prev_q >> 30));
        state_d = S_SADD;
      end
      S_SADD: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = seed_word;
        prev_d    = seed_word;
        if (idx_q == PosLast) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 10'd1;
          state_d = S_SMUL;
        end
      end
      S_RD1: begin
        cur_d   = ram_rdata;
        state_d = S_RD2;
      end
      S_RD2: begin
        nxt_d   = ram_rdata;
        state_d = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        pos_d  = k_q + 10'd1;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = key_byte;
          state_d     = S_IDLE;
        end else begin
          res_d   = key_byte;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= PosFull;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    idx_q      <= idx_d;
    prev_q     <= prev_d;
    prod_q     <= prod_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    data_q     <= data_d;
    res_q      <= res_d;
    out_byte_q <= out_byte_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosFull)
    else $error("word position beyond twist point");

  a_data_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (mode_i == MODE_DATA) |=> (state_q == S_RD1) && (k_q <= PosLast))
    else $error("data transfer took a bad word index");

  a_seed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SADD) && (idx_q == PosLast) |=> (state_q == S_IDLE) && (pos_q == PosFull))
    else $error("reseed did not end with twist pending");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) && out_free |=> out_valid_o && (state_q == S_IDLE))
    else $error("finished byte not presented");

endmodule
